>>> hdl/rsmp_pkg.sv
// Shared types and constants for the polyphase rational resampler.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps
`default_nettype none
package rsmp_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int DEF_MAX_PHASES = 32;
	localparam int DEF_MAX_TAPS_PER_PHASE = 64;
	localparam int DOWN_LIMIT = 1024;
	localparam int IDX_W = 11;
	localparam int UP_W = 6;
	localparam int DOWN_W = 11;
	localparam int TAPS_W = 7;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int SKIP_W = 10;
	localparam int DVD_W = 11;
	localparam int DVS_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_UP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAPS = 2'd2;

	typedef enum logic [1:0] {
		MODE_COEF = 2'd0,
		MODE_SAMPLE = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [IDX_W-1:0] coef_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_st_t;
endpackage
`default_nettype wire

>>> hdl/rsmp_in_if.sv
// Input channel: valid/ready handshake with command and sample payload.
// Depends on rsmp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rsmp_in_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	rsmp_pkg::coef_idx_t coeff_index;
	rsmp_pkg::sample_t coeff_value;
	rsmp_pkg::sample_t sample_re;
	rsmp_pkg::sample_t sample_im;
	modport source (output valid, mode, coeff_index, coeff_value, sample_re, sample_im,
		input ready);
	modport sink (input valid, mode, coeff_index, coeff_value, sample_re, sample_im,
		output ready);
endinterface
`default_nettype wire

>>> hdl/rsmp_out_if.sv
// Output channel: valid/ready handshake carrying one filtered complex sample.
// Depends on rsmp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rsmp_out_if;
	logic valid;
	logic ready;
	rsmp_pkg::sample_t out_re;
	rsmp_pkg::sample_t out_im;
	logic last;
	modport source (output valid, out_re, out_im, last, input ready);
	modport sink (input valid, out_re, out_im, last, output ready);
endinterface
`default_nettype wire

>>> hdl/rsmp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rsmp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [rsmp_pkg::DVD_W-1:0] dvd,
	input wire logic [rsmp_pkg::DVS_W-1:0] dvs,
	output rsmp_pkg::div_st_t st,
	output logic [rsmp_pkg::DVD_W-1:0] quo,
	output logic [rsmp_pkg::DVS_W-1:0] rem
);
	import rsmp_pkg::*;
	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] q_q;
	logic [DVS_W-1:0] r_q;
	logic [DVS_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;

	assign trial = {r_q, q_q[DVD_W-1]};
	assign diff = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dvd;
			r_q <= '0;
			d_q <= dvs;
		end else if (busy_q) begin
			if (!diff[DVS_W]) begin
				r_q <= diff[DVS_W-1:0];
				q_q <= {q_q[DVD_W-2:0], 1'b1};
			end else begin
				r_q <= trial[DVS_W-1:0];
				q_q <= {q_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign st = '{busy: busy_q, done: done_q};
	assign quo = q_q;
	assign rem = r_q;
endmodule
`default_nettype wire

>>> hdl/rsmp_mac.sv
// Complex-by-real multiply-accumulate with round-half-up and saturation.
// Depends on rsmp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_mac #(
	parameter int MAX_TAPS_PER_PHASE = rsmp_pkg::DEF_MAX_TAPS_PER_PHASE
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic clr,
	input wire logic en,
	input wire rsmp_pkg::sample_t coef,
	input wire rsmp_pkg::sample_t re,
	input wire rsmp_pkg::sample_t im,
	output logic busy,
	output rsmp_pkg::sample_t res_re,
	output rsmp_pkg::sample_t res_im
);
	import rsmp_pkg::*;
	localparam int SB = SAMPLE_BITS;
	localparam int F = SB - 1;
	localparam int ACC_W = 2 * SB + $clog2(MAX_TAPS_PER_PHASE) + 1;
	localparam int S_W = ACC_W - F;

	logic signed [2*SB-1:0] pre_s2;
	logic signed [2*SB-1:0] pim_s2;
	logic vld_s2;
	logic signed [ACC_W-1:0] acc_re_q;
	logic signed [ACC_W-1:0] acc_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= en;
		end
	end

	always_ff @(posedge clk) begin
		pre_s2 <= re * coef;
		pim_s2 <= im * coef;
		if (clr) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (vld_s2) begin
			acc_re_q <= acc_re_q + ACC_W'(pre_s2);
			acc_im_q <= acc_im_q + ACC_W'(pim_s2);
		end
	end

	function automatic sample_t rnd_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] x;
		logic signed [S_W-1:0] s;
		logic ovf;
		x = a + ACC_W'(1 <<< (F - 1));
		s = S_W'(x >>> F);
		ovf = (s[S_W-1:SB-1] != '0) && (s[S_W-1:SB-1] != '1);
		if (!ovf) begin
			rnd_sat = s[SB-1:0];
		end else if (s[S_W-1]) begin
			rnd_sat = {1'b1, {(SB-1){1'b0}}};
		end else begin
			rnd_sat = {1'b0, {(SB-1){1'b1}}};
		end
	endfunction

	assign busy = vld_s2;
	assign res_re = rnd_sat(acc_re_q);
	assign res_im = rnd_sat(acc_im_q);
endmodule
`default_nettype wire

>>> hdl/polyphase_rational_resampler_top.sv
// Polyphase rational resampler top: sequencer, coefficient and history memories.
// Depends on rsmp_pkg, rsmp_in_if, rsmp_out_if, rsmp_div, rsmp_mac.
//
// Usage: commands enter on din (mode 0 coefficient write, 1 sample, 2 clear
// history/phase/skip); filtered complex outputs leave on dout, last marking the
// final output caused by a sample. The rate registers (up factor, down step,
// taps per phase) are written through cfg_we/cfg_idx/cfg_data; the user must
// write them only while idle, the block does not enforce it. After reset the
// coefficient memory is cleared, one entry per cycle, din.ready low.
// Per transfer on din, all through one shared divider and one MAC:
//   mode 0: 11-step divide for k mod/div up_rate, then write.
//   mode 2, or mode 1 while skipping: handled in the idle state alone.
//   mode 1 producing n outputs: a divide for the phase, then n output passes.
// Each output needs taps_per_phase MAC steps plus a pipeline drain and an
// 11-step divide for the phase step. Results sit in an output register; if the
// receiver stalls, the sequencer waits at that register and din stays not ready.
`timescale 1ns / 1ps
`default_nettype none
module polyphase_rational_resampler_top #(
	parameter int MAX_PHASES = rsmp_pkg::DEF_MAX_PHASES,
	parameter int MAX_TAPS_PER_PHASE = rsmp_pkg::DEF_MAX_TAPS_PER_PHASE
) (
	input wire logic clk,
	input wire logic arst_n,
	rsmp_in_if.sink din,
	rsmp_out_if.source dout,
	input wire logic cfg_we,
	input wire logic [rsmp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [rsmp_pkg::CFG_W-1:0] cfg_data
);
	import rsmp_pkg::*;
	localparam int DEPTH = MAX_PHASES * MAX_TAPS_PER_PHASE;
	localparam int CA_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PH_W = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
	localparam int HW = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1;
	localparam int TC_W = $clog2(MAX_TAPS_PER_PHASE + 1);
	localparam logic [CA_W-1:0] TAPS_C = CA_W'(MAX_TAPS_PER_PHASE);
	localparam logic [CA_W-1:0] CLR_END = CA_W'(DEPTH - 1);
	localparam logic [HW-1:0] WP_END = HW'(MAX_TAPS_PER_PHASE - 1);
	localparam logic [DVS_W-1:0] UMAX = DVS_W'(MAX_PHASES);
	localparam logic [8:0] TMAX = 9'(MAX_TAPS_PER_PHASE);

	typedef enum logic [7:0] {
		S_CLR = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_WDIV = 8'b0000_0100,
		S_PMOD = 8'b0000_1000,
		S_MAC = 8'b0001_0000,
		S_DRAIN = 8'b0010_0000,
		S_ADV = 8'b0100_0000,
		S_OUT = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [UP_W-1:0] up_q;
	logic [DOWN_W-1:0] down_q;
	logic [TAPS_W-1:0] taps_q;
	logic [CA_W-1:0] clr_cnt_q;
	sample_t cval_q;
	logic [PH_W-1:0] phase_q;
	logic [SKIP_W-1:0] skip_q;
	logic [HW-1:0] wp_q;
	logic [MAX_TAPS_PER_PHASE-1:0] hv_q;
	logic [TC_W-1:0] tap_q;
	logic [DVD_W-1:0] adv_q;
	logic rd_vld_s1;
	logic hv_s1;
	logic out_vld_q;
	sample_t out_re_q;
	sample_t out_im_q;
	logic out_last_q;

	logic [DVS_W-1:0] u_c;
	logic [DOWN_W-1:0] d_c;
	logic [TC_W-1:0] t_c;
	logic [8:0] t9;

	logic div_start;
	logic [DVD_W-1:0] div_dvd;
	div_st_t div_st;
	logic [DVD_W-1:0] div_quo;
	logic [DVS_W-1:0] div_rem;

	logic mac_clr;
	logic mac_busy;
	sample_t mac_re;
	sample_t mac_im;

	logic in_xfer;
	logic out_free;
	logic [HW-1:0] wp_nx;
	logic [TC_W-1:0] age;
	logic [HW-1:0] h_ra;
	logic [CA_W-1:0] c_ra;
	logic c_we;
	logic [CA_W-1:0] c_wa;
	sample_t c_wd;
	logic coef_ok;

	sample_t cmem [DEPTH];
	logic [2*SAMPLE_BITS-1:0] hmem [MAX_TAPS_PER_PHASE];
	sample_t coef_s1;
	logic [2*SAMPLE_BITS-1:0] hd_s1;

	always_comb begin
		if (up_q == '0) begin
			u_c = DVS_W'(1);
		end else if (DVS_W'(up_q) > UMAX) begin
			u_c = UMAX;
		end else begin
			u_c = DVS_W'(up_q);
		end
		if (down_q == '0) begin
			d_c = DOWN_W'(1);
		end else if (down_q > DOWN_W'(DOWN_LIMIT)) begin
			d_c = DOWN_W'(DOWN_LIMIT);
		end else begin
			d_c = down_q;
		end
		if (taps_q == '0) begin
			t9 = 9'd1;
		end else if (9'(taps_q) > TMAX) begin
			t9 = TMAX;
		end else begin
			t9 = 9'(taps_q);
		end
		t_c = TC_W'(t9);
	end

	assign in_xfer = din.valid && din.ready;
	assign din.ready = (state_q == S_IDLE);
	assign out_free = !out_vld_q || dout.ready;
	assign wp_nx = (wp_q == WP_END) ? '0 : wp_q + 1'b1;
	assign age = t_c - 1'b1 - tap_q;
	assign h_ra = (wp_q >= HW'(age)) ? wp_q - HW'(age)
		: HW'((HW+1)'(wp_q) + (HW+1)'(MAX_TAPS_PER_PHASE) - (HW+1)'(age));
	assign c_ra = CA_W'(phase_q) * TAPS_C + CA_W'(tap_q);
	assign coef_ok = div_quo < DVD_W'(t_c);
	assign mac_clr = (state_q == S_PMOD && div_st.done) || (state_q == S_OUT && out_free);

	always_comb begin
		div_start = 1'b0;
		div_dvd = din.coeff_index;
		if (state_q == S_IDLE && in_xfer) begin
			if (mode_t'(din.mode) == MODE_COEF) begin
				div_start = 1'b1;
			end else if (mode_t'(din.mode) == MODE_SAMPLE && skip_q == '0) begin
				div_start = 1'b1;
				div_dvd = DVD_W'(phase_q);
			end
		end else if (state_q == S_DRAIN && !rd_vld_s1 && !mac_busy) begin
			div_start = 1'b1;
			div_dvd = DVD_W'(phase_q) + d_c;
		end
	end

	always_comb begin
		c_we = 1'b0;
		c_wa = clr_cnt_q;
		c_wd = '0;
		if (state_q == S_CLR) begin
			c_we = 1'b1;
		end else if (state_q == S_WDIV && div_st.done && coef_ok) begin
			c_we = 1'b1;
			c_wa = CA_W'(PH_W'(div_rem)) * TAPS_C
				+ CA_W'(t_c - 1'b1 - TC_W'(div_quo));
			c_wd = cval_q;
		end
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			cmem[c_wa] <= c_wd;
		end
		coef_s1 <= cmem[c_ra];
	end

	always_ff @(posedge clk) begin
		if (in_xfer && mode_t'(din.mode) == MODE_SAMPLE) begin
			hmem[wp_nx] <= {din.sample_re, din.sample_im};
		end
		hd_s1 <= hmem[h_ra];
	end

	always_ff @(posedge clk) begin
		hv_s1 <= hv_q[h_ra];
		if (in_xfer) begin
			cval_q <= din.coeff_value;
		end
		if (state_q == S_ADV && div_st.done) begin
			adv_q <= div_quo;
		end
		if (state_q == S_OUT && out_free) begin
			out_re_q <= mac_re;
			out_im_q <= mac_im;
			out_last_q <= (adv_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= UP_W'(1);
			down_q <= DOWN_W'(1);
			taps_q <= TAPS_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_UP: up_q <= cfg_data[UP_W-1:0];
				CFG_DOWN: down_q <= cfg_data[DOWN_W-1:0];
				CFG_TAPS: taps_q <= cfg_data[TAPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_cnt_q <= '0;
			phase_q <= '0;
			skip_q <= '0;
			wp_q <= '0;
			hv_q <= '0;
			tap_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_MAC);
			if (state_q == S_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == CLR_END) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						case (mode_t'(din.mode))
							MODE_COEF: state_q <= S_WDIV;
							MODE_SAMPLE: begin
								wp_q <= wp_nx;
								hv_q[wp_nx] <= 1'b1;
								if (skip_q != '0) begin
									skip_q <= skip_q - 1'b1;
								end else begin
									state_q <= S_PMOD;
								end
							end
							MODE_CLEAR: begin
								hv_q <= '0;
								phase_q <= '0;
								skip_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_WDIV: begin
					if (div_st.done) begin
						state_q <= S_IDLE;
					end
				end
				S_PMOD: begin
					if (div_st.done) begin
						phase_q <= PH_W'(div_rem);
						tap_q <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					tap_q <= tap_q + 1'b1;
					if (tap_q == t_c - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_vld_s1 && !mac_busy) begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (div_st.done) begin
						phase_q <= PH_W'(div_rem);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						tap_q <= '0;
						if (adv_q != '0) begin
							skip_q <= SKIP_W'(adv_q - 1'b1);
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MAC;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	rsmp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dvd(div_dvd),
		.dvs(u_c),
		.st(div_st),
		.quo(div_quo),
		.rem(div_rem)
	);

	rsmp_mac #(
		.MAX_TAPS_PER_PHASE(MAX_TAPS_PER_PHASE)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.clr(mac_clr),
		.en(rd_vld_s1),
		.coef(coef_s1),
		.re(hv_s1 ? sample_t'(hd_s1[2*SAMPLE_BITS-1:SAMPLE_BITS]) : sample_t'(0)),
		.im(hv_s1 ? sample_t'(hd_s1[SAMPLE_BITS-1:0]) : sample_t'(0)),
		.busy(mac_busy),
		.res_re(mac_re),
		.res_im(mac_im)
	);

	assign dout.valid = out_vld_q;
	assign dout.out_re = out_re_q;
	assign dout.out_im = out_im_q;
	assign dout.last = out_last_q;

`ifndef NO_ASSERTIONS
	a_coef_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && din.mode == MODE_COEF |=> state_q == S_WDIV && div_st.busy)
		else $error("coefficient transfer did not start divide");
	a_div_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == S_WDIV || state_q == S_PMOD || state_q == S_ADV)
		else $error("divider finished outside a waiting state");
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAC |-> tap_q < t_c)
		else $error("tap counter out of range");
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !dout.valid && !din.ready)
		else $error("activity during clearing pass");
	a_out_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_free && adv_q != '0 |=> state_q == S_IDLE && dout.last)
		else $error("final output not marked last");
`endif
endmodule
`default_nettype wire
